@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// prop must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ design/ssbs_pkg.sv @@
// ----------------------------------------------------------------------------
// ssbs_pkg
// Shared types and character codes for the SQL statement boundary scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssbs_pkg;

    localparam int CHAR_W = 8;
    localparam int CTX_W  = 3;

    localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_DASH   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;

    // reported lexical context
    typedef enum logic [CTX_W-1:0] {
        CTX_CODE   = 3'd0,
        CTX_SQUOTE = 3'd1,
        CTX_DQUOTE = 3'd2,
        CTX_BLOCK  = 3'd3,
        CTX_LINE   = 3'd4
    } t_ctx;

    typedef struct packed {
        logic is_terminator;
        t_ctx context_res;
    } t_scan_result;

endpackage

@@ design/sql_statement_boundary_scanner_top.sv @@
// ----------------------------------------------------------------------------
// sql_statement_boundary_scanner_top
// Scans SQL text a byte at a time, reports lexical context and statement ends.
// ----------------------------------------------------------------------------
// Channel   Handshake            Payload
// input     i_valid / o_ready    i_char_code, i_line_end, i_clear
// output    o_valid / i_ready    o_is_terminator, o_context_res
//
// One byte per cycle sustained while i_ready is high; a result appears in the cycle after its request.
// The context register and the result register update on the same edge.
// A held result stalls input only when i_ready is low.
// Reset (synchronous, active low) returns to plain code and empties the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sql_statement_boundary_scanner_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ssbs_pkg::CHAR_W-1:0] i_char_code,
    input  logic                        i_line_end,
    input  logic                        i_clear,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_is_terminator,
    output logic [ssbs_pkg::CTX_W-1:0]  o_context_res
);

    logic                   w_accept;
    ssbs_pkg::t_scan_result w_result;
    ssbs_pkg::t_scan_result r_result;
    logic                   r_out_valid;

    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    ssbs_lexer u_lexer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_char_code (i_char_code),
        .i_line_end  (i_line_end),
        .i_clear     (i_clear),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= w_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_is_terminator = r_result.is_terminator;
    assign o_context_res   = r_result.context_res;

    `ASSERT_CLK(a_empty_ready, i_clk, i_rst_n, r_out_valid || o_ready)
    `ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, w_accept, r_out_valid)
    `ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_out_valid && !i_ready,
        r_out_valid && $stable(r_result))

endmodule

@@ design/ssbs_lexer.sv @@
// ----------------------------------------------------------------------------
// ssbs_lexer
// Lexical context state machine; one byte per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssbs_lexer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [ssbs_pkg::CHAR_W-1:0] i_char_code,
    input  logic                       i_line_end,
    input  logic                       i_clear,
    output ssbs_pkg::t_scan_result     o_result
);

    typedef enum logic [3:0] {
        S_CODE       = 4'd0,
        S_SQUOTE     = 4'd1,
        S_DQUOTE     = 4'd2,
        S_BLOCK      = 4'd3,
        S_LINE       = 4'd4,
        S_CODE_DASH  = 4'd5,
        S_CODE_SLASH = 4'd6,
        S_SQUOTE_END = 4'd7,
        S_DQUOTE_END = 4'd8,
        S_BLOCK_STAR = 4'd9
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state w_base;
    t_state w_scan;
    logic   w_term;

    function automatic t_state scan_code(input logic [ssbs_pkg::CHAR_W-1:0] c);
        t_state s;
        if (c == ssbs_pkg::CH_SQUOTE) begin
            s = S_SQUOTE;
        end else if (c == ssbs_pkg::CH_DQUOTE) begin
            s = S_DQUOTE;
        end else if (c == ssbs_pkg::CH_DASH) begin
            s = S_CODE_DASH;
        end else if (c == ssbs_pkg::CH_SLASH) begin
            s = S_CODE_SLASH;
        end else begin
            s = S_CODE;
        end
        return s;
    endfunction

    assign w_base = i_clear ? S_CODE : r_state;

    always_comb begin
        w_term = 1'b0;
        case (w_base)
            S_SQUOTE: begin
                w_scan = (i_char_code == ssbs_pkg::CH_SQUOTE) ? S_SQUOTE_END : S_SQUOTE;
            end
            S_DQUOTE: begin
                w_scan = (i_char_code == ssbs_pkg::CH_DQUOTE) ? S_DQUOTE_END : S_DQUOTE;
            end
            S_BLOCK: begin
                w_scan = (i_char_code == ssbs_pkg::CH_STAR) ? S_BLOCK_STAR : S_BLOCK;
            end
            S_LINE: begin
                w_scan = S_LINE;
            end
            S_BLOCK_STAR: begin
                if (i_char_code == ssbs_pkg::CH_SLASH) begin
                    w_scan = S_CODE;
                end else if (i_char_code == ssbs_pkg::CH_STAR) begin
                    w_scan = S_BLOCK_STAR;
                end else begin
                    w_scan = S_BLOCK;
                end
            end
            S_CODE_DASH: begin
                w_term = (i_char_code == ssbs_pkg::CH_SEMI);
                w_scan = (i_char_code == ssbs_pkg::CH_DASH) ? S_LINE : scan_code(i_char_code);
            end
            S_CODE_SLASH: begin
                w_term = (i_char_code == ssbs_pkg::CH_SEMI);
                w_scan = (i_char_code == ssbs_pkg::CH_STAR) ? S_BLOCK : scan_code(i_char_code);
            end
            S_SQUOTE_END: begin
                w_term = (i_char_code == ssbs_pkg::CH_SEMI);
                w_scan = (i_char_code == ssbs_pkg::CH_SQUOTE) ? S_SQUOTE
                                                              : scan_code(i_char_code);
            end
            S_DQUOTE_END: begin
                w_term = (i_char_code == ssbs_pkg::CH_SEMI);
                w_scan = (i_char_code == ssbs_pkg::CH_DQUOTE) ? S_DQUOTE
                                                              : scan_code(i_char_code);
            end
            default: begin
                w_term = (i_char_code == ssbs_pkg::CH_SEMI);
                w_scan = scan_code(i_char_code);
            end
        endcase
    end

    // line end settles pending tokens and ends a line comment
    always_comb begin
        n_state = w_scan;
        if (i_line_end) begin
            case (w_scan)
                S_CODE_DASH, S_CODE_SLASH, S_SQUOTE_END, S_DQUOTE_END, S_LINE: begin
                    n_state = S_CODE;
                end
                S_BLOCK_STAR: begin
                    n_state = S_BLOCK;
                end
                default: begin
                    n_state = w_scan;
                end
            endcase
        end
    end

    always_comb begin
        o_result.is_terminator = w_term;
        case (n_state)
            S_SQUOTE, S_SQUOTE_END: o_result.context_res = ssbs_pkg::CTX_SQUOTE;
            S_DQUOTE, S_DQUOTE_END: o_result.context_res = ssbs_pkg::CTX_DQUOTE;
            S_BLOCK, S_BLOCK_STAR:  o_result.context_res = ssbs_pkg::CTX_BLOCK;
            S_LINE:                 o_result.context_res = ssbs_pkg::CTX_LINE;
            default:                o_result.context_res = ssbs_pkg::CTX_CODE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CODE;
        end else if (i_accept) begin
            r_state <= n_state;
        end
    end

    `ASSERT_CLK(a_term_in_code, i_clk, i_rst_n,
        !o_result.is_terminator || o_result.context_res == ssbs_pkg::CTX_CODE)
    `ASSERT_NEXT(a_line_end_settles, i_clk, i_rst_n, i_accept && i_line_end,
        r_state != S_LINE && r_state != S_CODE_DASH && r_state != S_CODE_SLASH &&
        r_state != S_SQUOTE_END && r_state != S_DQUOTE_END && r_state != S_BLOCK_STAR)

endmodule
